// ----- sv/psched_pkg.sv -----
// ---------------------------------------------------------------------------
// psched_pkg: shared types and constants for the priority bitmap scheduler
// Sizes, request codes, controller states and the command/status structs.
// ---------------------------------------------------------------------------
package psched_pkg;

  localparam int MaxTasks   = 64;
  localparam int NumPrio    = 256;
  localparam int TaskW      = $clog2(MaxTasks);
  localparam int PrioW      = $clog2(NumPrio);
  localparam int QuantW     = 8;
  localparam int LeafGroups = NumPrio / 8;
  localparam int MidGroups  = LeafGroups / 8;
  localparam logic [QuantW-1:0] QuantumResetVal = 8'd10;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NOP  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK,
    ST_OUT_RD,
    ST_OUT_WR,
    ST_IN_RD,
    ST_IN_WR,
    ST_PICK,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic decode;
    logic tick_upd;
    logic out_rd;
    logic out_wr;
    logic in_rd;
    logic in_wr;
    logic pick;
    logic result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enq_ok;
    logic deq_ok;
    logic is_tick;
    logic q_zero;
    logic run_queued;
    logic out_busy;
  } stat_t;

  // index of the highest set bit of an 8-bit group, 0 when empty
  function automatic logic [2:0] hi_bit8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

// ----- sv/priority_bitmap_ready_scheduler.sv -----
// ---------------------------------------------------------------------------
// priority_bitmap_ready_scheduler: ready-queue scheduler with 256 priorities
// Three-level occupancy bitmap over linked FIFOs of task ids.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transfer: tuser = request kind
//   (enqueue, dequeue, tick), tdata = task id, priority and commit flag.
//   m_axis returns exactly one result per request: the head task of the
//   best priority, an empty flag, a switch flag and a quantum-expired flag.
//   cfg_we/cfg_wdata write the quantum reload value; write only while idle.
// Timing:
//   The block handles one request at a time. After the decode step, a plain
//   or ignored request goes straight to pick and result; a tick updates the
//   quantum first; enqueue inserts and dequeue unlinks the task; a tick that
//   rotates the running task unlinks and then inserts it. Each step is one
//   registered table read or one read-modify-write of the task and queue
//   tables. The next request is accepted in the idle state that follows
//   the result load; s_axis_tready is high only between requests.
// Reset: bitmaps, queued flags, running task and the output valid clear;
//   the quantum reload returns to 10. Queue and task tables are not cleared.
// Stall: a result waits in the output register; the next request is still
//   accepted and its result waits until the register is free.
// ---------------------------------------------------------------------------
module priority_bitmap_ready_scheduler
  import psched_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // task_id[5:0], task_prio[13:6], commit[14], 0
  input  logic [1:0]        s_axis_tuser,  // req_type[1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // chosen_task[5:0], none_ready[6],
                                           // switched[7], quantum_expired[8], 0
  input  logic              cfg_we,
  input  logic [QuantW-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  logic [TaskW-1:0] out_task;
  logic             out_none, out_switched, out_expired;

  psched_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  psched_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_req       (s_axis_tuser),
    .in_id        (s_axis_tdata[TaskW-1:0]),
    .in_prio      (s_axis_tdata[TaskW+PrioW-1:TaskW]),
    .in_commit    (s_axis_tdata[TaskW+PrioW]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_task     (out_task),
    .out_none     (out_none),
    .out_switched (out_switched),
    .out_expired  (out_expired)
  );

  assign s_axis_tready = cmd.accept && s_axis_tvalid;
  assign m_axis_tdata  = {7'd0, out_expired, out_switched, out_none, out_task};

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // an empty scheduler reports task zero
  a_empty_task: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[6]) |-> (m_axis_tdata[5:0] == '0))
    else $error("nonzero task reported with no ready task");

  // an empty scheduler never switches
  a_empty_noswitch: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[6]) |-> !m_axis_tdata[7])
    else $error("switch reported with no ready task");

  // nothing is presented right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

// ----- sv/psched_ctrl.sv -----
// ---------------------------------------------------------------------------
// psched_ctrl: scheduler sequencer
// Steps one request through table reads, link updates, pick and result.
// ---------------------------------------------------------------------------
module psched_ctrl
  import psched_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state, state_next;
  logic   rotate, rotate_next;

  // state and rotate flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rotate <= 1'b0;
    end else begin
      state  <= state_next;
      rotate <= rotate_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    rotate_next = rotate;
    case (state)
      ST_IDLE: begin
        rotate_next = 1'b0;
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.enq_ok)       state_next = ST_IN_RD;
        else if (stat.deq_ok)  state_next = ST_OUT_RD;
        else if (stat.is_tick) state_next = ST_TICK;
        else                   state_next = ST_PICK;
      end
      ST_TICK: begin
        if (stat.q_zero && stat.run_queued) begin
          rotate_next = 1'b1;
          state_next  = ST_OUT_RD;
        end else begin
          state_next = ST_PICK;
        end
      end
      ST_OUT_RD: state_next = ST_OUT_WR;
      ST_OUT_WR: state_next = rotate ? ST_IN_RD : ST_PICK;
      ST_IN_RD:  state_next = ST_IN_WR;
      ST_IN_WR:  state_next = ST_PICK;
      ST_PICK:   state_next = ST_RESULT;
      ST_RESULT: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.accept   = 1'b1;
      ST_DECODE: cmd.decode   = 1'b1;
      ST_TICK:   cmd.tick_upd = 1'b1;
      ST_OUT_RD: cmd.out_rd   = 1'b1;
      ST_OUT_WR: cmd.out_wr   = 1'b1;
      ST_IN_RD:  cmd.in_rd    = 1'b1;
      ST_IN_WR:  cmd.in_wr    = 1'b1;
      ST_PICK:   cmd.pick     = 1'b1;
      ST_RESULT: cmd.result   = !stat.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- sv/psched_dp.sv -----
// ---------------------------------------------------------------------------
// psched_dp: scheduler datapath
// Task and queue tables, occupancy bitmaps, running task and result register.
// ---------------------------------------------------------------------------
module psched_dp
  import psched_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [1:0]        in_req,
  input  logic [TaskW-1:0]  in_id,
  input  logic [PrioW-1:0]  in_prio,
  input  logic              in_commit,
  input  logic              cfg_we,
  input  logic [QuantW-1:0] cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TaskW-1:0]  out_task,
  output logic              out_none,
  output logic              out_switched,
  output logic              out_expired
);

  // memories
  logic [TaskW-1:0]  head_mem [NumPrio];
  logic [TaskW-1:0]  tail_mem [NumPrio];
  logic [TaskW-1:0]  fwd_mem  [MaxTasks];
  logic [TaskW-1:0]  back_mem [MaxTasks];
  logic [PrioW-1:0]  lvl_mem  [MaxTasks];
  logic [QuantW-1:0] quant_mem[MaxTasks];

  logic [TaskW-1:0]  head_q, tail_q, fwd_q, back_q;
  logic [PrioW-1:0]  lvl_q;
  logic [QuantW-1:0] quant_q;

  // item and control registers
  req_t              req;
  logic [TaskW-1:0]  target;
  logic [PrioW-1:0]  prio;
  logic              commit;
  logic              expired;
  logic [PrioW-1:0]  p_reg;
  logic              ready;
  logic [TaskW-1:0]  running;
  logic [QuantW-1:0] quantum_reload;
  logic [MaxTasks-1:0] queued, loaded;

  // occupancy bitmaps
  logic [NumPrio-1:0]    leaf_bits;
  logic [LeafGroups-1:0] middle_bits;
  logic [MidGroups-1:0]  top_bits;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) quantum_reload <= QuantumResetVal;
    else if (cfg_we) quantum_reload <= cfg_wdata;
  end

  // status
  assign stat.enq_ok     = (req == REQ_ENQ) && !queued[target];
  assign stat.deq_ok     = (req == REQ_DEQ) && queued[target];
  assign stat.is_tick    = (req == REQ_TICK);
  assign stat.q_zero     = (quant_q == '0);
  assign stat.run_queued = queued[target];
  assign stat.out_busy   = out_valid && !out_ready;

  // best priority from the bitmaps
  logic [2:0]       h8, m, l;
  logic [1:0]       h;
  logic [PrioW-1:0] p_best;
  always_comb begin
    h8     = hi_bit8({{(8-MidGroups){1'b0}}, top_bits});
    h      = h8[1:0];
    m      = hi_bit8(middle_bits[{h, 3'd0} +: 8]);
    l      = hi_bit8(leaf_bits[{h, m, 3'd0} +: 8]);
    p_best = {h, m, l};
  end

  // unlink decisions
  logic is_head, is_tail, both;
  assign is_head = (head_q == target);
  assign is_tail = (tail_q == target);
  assign both    = is_head && is_tail;
  logic slot_empty;
  assign slot_empty = !leaf_bits[p_reg];

  // bitmap update: clear cascades up only when a group empties
  logic [NumPrio-1:0]    leaf_clr;
  logic [LeafGroups-1:0] mid_clr;
  logic [MidGroups-1:0]  top_clr;
  always_comb begin
    leaf_clr = leaf_bits;
    leaf_clr[p_reg] = 1'b0;
    mid_clr = middle_bits;
    top_clr = top_bits;
    if (leaf_clr[{p_reg[PrioW-1:3], 3'd0} +: 8] == 8'd0) begin
      mid_clr[p_reg[PrioW-1:3]] = 1'b0;
      if (mid_clr[{p_reg[PrioW-1:6], 3'd0} +: 8] == 8'd0)
        top_clr[p_reg[PrioW-1:6]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_bits   <= '0;
      middle_bits <= '0;
      top_bits    <= '0;
      queued      <= '0;
      loaded      <= '0;
    end else begin
      if (cmd.decode && stat.enq_ok) loaded[target] <= 1'b1;
      if (cmd.out_wr) begin
        queued[target] <= 1'b0;
        if (both) begin
          leaf_bits   <= leaf_clr;
          middle_bits <= mid_clr;
          top_bits    <= top_clr;
        end
      end
      if (cmd.in_wr) begin
        queued[target] <= 1'b1;
        if (slot_empty) begin
          leaf_bits[p_reg]               <= 1'b1;
          middle_bits[p_reg[PrioW-1:3]]  <= 1'b1;
          top_bits[p_reg[PrioW-1:6]]     <= 1'b1;
        end
      end
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req     <= req_t'(in_req);
      target  <= (req_t'(in_req) == REQ_TICK) ? running : in_id;
      prio    <= in_prio;
      commit  <= in_commit;
      expired <= 1'b0;
    end
    if (cmd.decode) p_reg <= prio;
    if (cmd.out_rd) p_reg <= lvl_q;
    if (cmd.tick_upd && stat.q_zero) begin
      expired <= 1'b1;
      commit  <= 1'b1;
    end
    if (cmd.pick) ready <= (top_bits != '0);
  end

  // level table
  always_ff @(posedge clk) begin
    if (cmd.decode && stat.enq_ok) lvl_mem[target] <= prio;
    if (cmd.decode) lvl_q <= lvl_mem[target];
  end

  // quantum table
  logic              q_we;
  logic [QuantW-1:0] q_wd;
  always_comb begin
    q_we = 1'b0;
    q_wd = quantum_reload;
    if (cmd.decode && stat.enq_ok && !loaded[target]) q_we = 1'b1;
    if (cmd.tick_upd) begin
      q_we = 1'b1;
      q_wd = stat.q_zero ? quantum_reload : quant_q - 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (q_we) quant_mem[target] <= q_wd;
    if (cmd.decode) quant_q <= quant_mem[target];
  end

  // head table
  logic             hd_we;
  logic [TaskW-1:0] hd_wd;
  logic [PrioW-1:0] hd_ra;
  always_comb begin
    hd_we = (cmd.out_wr && is_head && !both) || (cmd.in_wr && slot_empty);
    hd_wd = cmd.in_wr ? target : fwd_q;
    hd_ra = cmd.pick ? p_best : lvl_q;
  end
  always_ff @(posedge clk) begin
    if (hd_we) head_mem[p_reg] <= hd_wd;
    if (cmd.out_rd || cmd.pick) head_q <= head_mem[hd_ra];
  end

  // tail table
  logic             tl_we;
  logic [TaskW-1:0] tl_wd;
  logic [PrioW-1:0] tl_ra;
  always_comb begin
    tl_we = (cmd.out_wr && is_tail && !both) || cmd.in_wr;
    tl_wd = cmd.in_wr ? target : back_q;
    tl_ra = cmd.in_rd ? p_reg : lvl_q;
  end
  always_ff @(posedge clk) begin
    if (tl_we) tail_mem[p_reg] <= tl_wd;
    if (cmd.out_rd || cmd.in_rd) tail_q <= tail_mem[tl_ra];
  end

  // forward links
  logic             fw_we;
  logic [TaskW-1:0] fw_wa, fw_wd;
  always_comb begin
    fw_we = (cmd.out_wr && !is_head && !both) || (cmd.in_wr && !slot_empty);
    fw_wa = cmd.in_wr ? tail_q : back_q;
    fw_wd = cmd.in_wr ? target : fwd_q;
  end
  always_ff @(posedge clk) begin
    if (fw_we) fwd_mem[fw_wa] <= fw_wd;
    if (cmd.out_rd) fwd_q <= fwd_mem[target];
  end

  // backward links
  logic             bk_we;
  logic [TaskW-1:0] bk_wa, bk_wd;
  always_comb begin
    bk_we = (cmd.out_wr && !is_tail && !both) || (cmd.in_wr && !slot_empty);
    bk_wa = cmd.in_wr ? target : fwd_q;
    bk_wd = cmd.in_wr ? tail_q : back_q;
  end
  always_ff @(posedge clk) begin
    if (bk_we) back_mem[bk_wa] <= bk_wd;
    if (cmd.out_rd) back_q <= back_mem[target];
  end

  // selection, running task and result register
  logic [TaskW-1:0] sel;
  logic             take;
  assign sel  = ready ? head_q : '0;
  assign take = commit && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.result) begin
        out_valid <= 1'b1;
        if (take) running <= sel;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_task     <= sel;
      out_none     <= !ready;
      out_switched <= take && (sel != running);
      out_expired  <= expired;
    end
  end

endmodule

// ----- tb/sv/tb_priority_bitmap_ready_scheduler.sv -----
// ---------------------------------------------------------------------------
// tb_priority_bitmap_ready_scheduler: self-checking bench for the scheduler
// Drives enqueue/dequeue/tick requests in random bursts, predicts each result
// with a behavioral ready-queue model and compares every output transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_priority_bitmap_ready_scheduler;
  import psched_pkg::*;

  typedef struct packed {
    req_t             kind;
    logic [TaskW-1:0] id;
    logic [PrioW-1:0] prio;
    logic             commit;
  } sched_req_t;

  typedef struct packed {
    logic [TaskW-1:0] chosen;
    logic             none;
    logic             switched;
    logic             expired;
  } sched_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              cfg_we = 1'b0;
  logic [QuantW-1:0] cfg_wdata = '0;

  priority_bitmap_ready_scheduler dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler shadow state
  logic [QuantW-1:0] m_reload;
  logic [3:0]        m_top;
  logic [7:0]        m_mid  [MidGroups];
  logic [7:0]        m_leaf [LeafGroups];
  logic [TaskW-1:0]  m_head [NumPrio];
  logic [TaskW-1:0]  m_tail [NumPrio];
  logic [TaskW-1:0]  m_next [MaxTasks];
  logic [TaskW-1:0]  m_prev [MaxTasks];
  logic [PrioW-1:0]  m_lvl  [MaxTasks];
  logic [QuantW-1:0] m_quant[MaxTasks];
  logic              m_queued[MaxTasks];
  logic              m_loaded[MaxTasks];
  logic [TaskW-1:0]  m_run;

  sched_req_t pending_reqs[$];
  sched_res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit drain_wait = 0;

  function automatic int highest(input logic [7:0] v);
    int r;
    r = 0;
    for (int i = 0; i < 8; i++) if (v[i]) r = i;
    return r;
  endfunction

  task automatic sched_reset();
    m_reload = 8'd10;
    m_top = '0;
    m_run = '0;
    foreach (m_mid[i]) m_mid[i] = '0;
    foreach (m_leaf[i]) m_leaf[i] = '0;
    for (int i = 0; i < MaxTasks; i++) begin
      m_queued[i] = 1'b0;
      m_loaded[i] = 1'b0;
      m_next[i] = '0;
      m_prev[i] = '0;
      m_lvl[i] = '0;
      m_quant[i] = '0;
    end
  endtask

  task automatic queue_insert(input int t);
    int p;
    p = m_lvl[t];
    if (!m_leaf[p>>3][p&7]) begin
      m_leaf[p>>3][p&7] = 1'b1;
      m_mid[p>>6][(p>>3)&7] = 1'b1;
      m_top[p>>6] = 1'b1;
      m_head[p] = TaskW'(t);
      m_tail[p] = TaskW'(t);
    end else begin
      m_prev[t] = m_tail[p];
      m_next[m_tail[p]] = TaskW'(t);
      m_tail[p] = TaskW'(t);
    end
    m_queued[t] = 1'b1;
  endtask

  task automatic queue_remove(input int t);
    int p;
    bit hd, tl;
    logic [TaskW-1:0] f, b;
    p = m_lvl[t];
    hd = (m_head[p] == t);
    tl = (m_tail[p] == t);
    f = m_next[t];
    b = m_prev[t];
    if (hd && tl) begin
      m_leaf[p>>3][p&7] = 1'b0;
      if (m_leaf[p>>3] == 0) begin
        m_mid[p>>6][(p>>3)&7] = 1'b0;
        if (m_mid[p>>6] == 0) m_top[p>>6] = 1'b0;
      end
    end else begin
      if (hd) m_head[p] = f; else m_next[b] = f;
      if (tl) m_tail[p] = b; else m_prev[f] = b;
    end
    m_queued[t] = 1'b0;
  endtask

  // apply one request and append the expected result
  task automatic sched_predict(input sched_req_t r);
    sched_res_t res;
    bit cm;
    int h, md, l;
    logic [TaskW-1:0] old_run;
    cm = r.commit;
    old_run = m_run;
    res = '0;
    case (r.kind)
      REQ_ENQ: begin
        if (!m_queued[r.id]) begin
          m_lvl[r.id] = r.prio;
          if (!m_loaded[r.id]) begin
            m_quant[r.id] = m_reload;
            m_loaded[r.id] = 1'b1;
          end
          queue_insert(r.id);
        end
      end
      REQ_DEQ: if (m_queued[r.id]) queue_remove(r.id);
      REQ_TICK: begin
        if (m_quant[m_run] != 0) m_quant[m_run] = m_quant[m_run] - 1'b1;
        else begin
          res.expired = 1'b1;
          m_quant[m_run] = m_reload;
          if (m_queued[m_run]) begin
            queue_remove(m_run);
            queue_insert(m_run);
          end
          cm = 1'b1;
        end
      end
      default: ;
    endcase
    if (m_top == 0) begin
      res.chosen = '0;
      res.none = 1'b1;
    end else begin
      h = highest({4'b0, m_top});
      md = highest(m_mid[h]);
      l = highest(m_leaf[h*8+md]);
      res.chosen = m_head[h*64+md*8+l];
      if (cm) m_run = res.chosen;
    end
    res.switched = (m_run != old_run);
    expected_results.push_back(res);
  endtask

  // sender: bursts with random gaps, plus a full drain pause on request
  int gap = 0;
  int burst = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sched_predict(pending_reqs.pop_front());
      end
      if (s_axis_tvalid && !(s_axis_tready)) begin
        // keep offering the same item
      end else if (drain_wait && expected_results.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap > 0) begin
        gap <= gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_reqs[0].kind;
        s_axis_tdata <= {1'b0, pending_reqs[0].commit, pending_reqs[0].prio,
                         pending_reqs[0].id};
        if (burst <= 1) begin
          burst <= $urandom_range(1, 12);
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end else begin
          burst <= burst - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (cycles % 2000 < 600) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    sched_res_t got, exp_r;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[5:0], m_axis_tdata[6], m_axis_tdata[7], m_axis_tdata[8]};
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.chosen !== exp_r.chosen) begin
          $error("chosen_task exp %0d got %0d", exp_r.chosen, got.chosen);
          errors++;
        end
        if (got.none !== exp_r.none) begin
          $error("none_ready exp %0d got %0d", exp_r.none, got.none);
          errors++;
        end
        if (got.switched !== exp_r.switched) begin
          $error("switched exp %0d got %0d", exp_r.switched, got.switched);
          errors++;
        end
        if (got.expired !== exp_r.expired) begin
          $error("quantum_expired exp %0d got %0d", exp_r.expired, got.expired);
          errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // test item helpers
  task automatic add_req(input req_t k, input int id, input int prio, input bit cm);
    sched_req_t r;
    r.kind = k;
    r.id = TaskW'(id);
    r.prio = PrioW'(prio);
    r.commit = cm;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reload(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_reload = v;
  endtask

  task automatic random_phase(input int n, input int prio_span);
    int k, id;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      id = $urandom_range(0, MaxTasks - 1);
      // ticks/commits only once task 0 (running at reset) is safe; the
      // directed part enqueues task 0 first, and commits pick loaded tasks
      if (k < 4) add_req(REQ_ENQ, id, (prio_span == 255) ? $urandom_range(0, 255)
                         : $urandom_range(0, prio_span) * (256 / (prio_span + 1)),
                         $urandom_range(0, 1));
      else if (k < 7) add_req(REQ_DEQ, id, $urandom_range(0, 255), $urandom_range(0, 1));
      else if (k < 9) add_req(REQ_TICK, id, $urandom_range(0, 255), $urandom_range(0, 1));
      else add_req(REQ_NOP, id, $urandom_range(0, 255), $urandom_range(0, 1));
    end
  endtask

  initial begin
    sched_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty scheduler, extremes, ignored requests, rotation
    add_req(REQ_NOP, 0, 0, 1);
    add_req(REQ_DEQ, 5, 0, 1);
    add_req(REQ_ENQ, 0, 0, 0);
    add_req(REQ_ENQ, 63, 255, 1);
    add_req(REQ_ENQ, 63, 3, 0);
    add_req(REQ_ENQ, 1, 255, 0);
    add_req(REQ_ENQ, 2, 128, 0);
    add_req(REQ_ENQ, 3, 64, 1);
    add_req(REQ_DEQ, 63, 0, 1);
    add_req(REQ_DEQ, 63, 0, 0);
    for (int i = 0; i < 12; i++) add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_DEQ, 1, 0, 1);
    add_req(REQ_DEQ, 2, 0, 0);
    add_req(REQ_ENQ, 42, 170, 1);
    wait_idle();
    // every task loaded so no tick reads an unwritten quantum
    write_reload(8'd0);
    for (int i = 0; i < MaxTasks; i++) add_req(REQ_ENQ, i, $urandom_range(0, 255), 0);
    for (int i = 0; i < MaxTasks; i++) add_req(REQ_DEQ, i, 0, 0);
    random_phase(40, 7);
    wait_idle();
    write_reload(8'd255);
    random_phase(80, 255);
    // long receiver hold-off while the sender keeps offering
    hold_off = 300;
    wait_idle();
    write_reload(8'd2);
    random_phase(80, 3);
    drain_wait = 1;
    wait_idle();
    drain_wait = 0;
    write_reload(8'd0);
    random_phase(60, 255);
    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- priority_bitmap_ready_scheduler.f -----
sv/psched_pkg.sv
sv/psched_ctrl.sv
sv/psched_dp.sv
sv/priority_bitmap_ready_scheduler.sv
tb/sv/tb_priority_bitmap_ready_scheduler.sv
